// File: rtl/core/cs_pkg.sv
package cs_pkg;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	localparam logic [2:0] MODE_TEXT       = 3'd0;
	localparam logic [2:0] MODE_SLASH      = 3'd1;
	localparam logic [2:0] MODE_LINE       = 3'd2;
	localparam logic [2:0] MODE_BLOCK      = 3'd3;
	localparam logic [2:0] MODE_BLOCK_STAR = 3'd4;
	localparam logic [2:0] MODE_QUOTE      = 3'd5;
	localparam logic [2:0] MODE_QUOTE_ESC  = 3'd6;

	localparam int QUEUE_DEPTH = 4;

	// Work for the output side: up to two bytes, and whether the text ends here.
	typedef struct packed {
		logic [1:0] nbytes;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       last;
	} cmd_t;

endpackage

// File: rtl/core/cs_in_if.sv
interface cs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

// File: rtl/core/cs_out_if.sv
interface cs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_text;

	modport source (output valid, output out_byte, output has_byte, output end_of_text,
		input ready);
	modport sink (input valid, input out_byte, input has_byte, input end_of_text,
		output ready);
endinterface

// File: rtl/core/cs_front.sv
module cs_front (
	input  logic          clk,
	input  logic          arst_n,
	cs_in_if.sink         text,
	input  logic          full,
	output logic          push,
	output cs_pkg::cmd_t  cmd
);

	logic [2:0] mode_q, mode_d;
	logic       quote_q, quote_d;
	logic       accept;
	logic [7:0] b;
	logic [7:0] closing;

	assign text.ready = !full;
	assign accept     = text.valid && !full;
	assign b          = text.in_byte;
	assign closing    = quote_q ? cs_pkg::CH_SQUOTE : cs_pkg::CH_DQUOTE;

	always_comb begin
		mode_d          = mode_q;
		quote_d         = quote_q;
		cmd.nbytes      = 2'd0;
		cmd.first_byte  = b;
		cmd.second_byte = b;
		cmd.last        = text.is_last;
		unique case (mode_q)
			cs_pkg::MODE_SLASH: begin
				if (b == cs_pkg::CH_STAR) begin
					mode_d = cs_pkg::MODE_BLOCK;
				end else if (b == cs_pkg::CH_SLASH) begin
					mode_d = cs_pkg::MODE_LINE;
				end else begin
					// release the held slash ahead of this byte
					cmd.nbytes     = 2'd2;
					cmd.first_byte = cs_pkg::CH_SLASH;
					mode_d         = cs_pkg::MODE_TEXT;
					if (b == cs_pkg::CH_DQUOTE || b == cs_pkg::CH_SQUOTE) begin
						quote_d = (b == cs_pkg::CH_SQUOTE);
						mode_d  = cs_pkg::MODE_QUOTE;
					end
				end
			end
			cs_pkg::MODE_LINE: begin
				if (b == cs_pkg::CH_NL) begin
					cmd.nbytes = 2'd1;
					mode_d     = cs_pkg::MODE_TEXT;
				end
			end
			cs_pkg::MODE_BLOCK: begin
				if (b == cs_pkg::CH_STAR) mode_d = cs_pkg::MODE_BLOCK_STAR;
			end
			cs_pkg::MODE_BLOCK_STAR: begin
				if (b == cs_pkg::CH_SLASH) mode_d = cs_pkg::MODE_TEXT;
				else if (b != cs_pkg::CH_STAR) mode_d = cs_pkg::MODE_BLOCK;
			end
			cs_pkg::MODE_QUOTE: begin
				cmd.nbytes = 2'd1;
				if (b == cs_pkg::CH_BSLASH) mode_d = cs_pkg::MODE_QUOTE_ESC;
				else if (b == closing) mode_d = cs_pkg::MODE_TEXT;
			end
			cs_pkg::MODE_QUOTE_ESC: begin
				cmd.nbytes = 2'd1;
				mode_d     = cs_pkg::MODE_QUOTE;
			end
			default: begin
				if (b == cs_pkg::CH_SLASH) begin
					// a slash on the final byte cannot open anything: pass it
					if (text.is_last) cmd.nbytes = 2'd1;
					else mode_d = cs_pkg::MODE_SLASH;
				end else begin
					cmd.nbytes = 2'd1;
					if (b == cs_pkg::CH_DQUOTE || b == cs_pkg::CH_SQUOTE) begin
						quote_d = (b == cs_pkg::CH_SQUOTE);
						mode_d  = cs_pkg::MODE_QUOTE;
					end
				end
			end
		endcase
		if (text.is_last) begin
			mode_d  = cs_pkg::MODE_TEXT;
			quote_d = 1'b0;
		end
	end

	// a beat that yields nothing and does not end the text needs no work behind
	assign push = accept && (cmd.nbytes != 2'd0 || text.is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= cs_pkg::MODE_TEXT;
			quote_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			quote_q <= quote_d;
		end
	end

	a_push_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cmd.nbytes != 2'd0 || cmd.last))
		else $error("empty command pushed");

	a_last_resets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		accept && text.is_last |=> mode_q == cs_pkg::MODE_TEXT && !quote_q)
		else $error("scan state not cleared after final byte");

endmodule

// File: rtl/core/cs_queue.sv
module cs_queue #(
	parameter int DEPTH = cs_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cs_pkg::cmd_t wr,
	output logic         full,
	output logic         head_valid,
	output cs_pkg::cmd_t head,
	input  logic         pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cs_pkg::cmd_t    mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
		advance = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= advance(wr_ptr_q);
			if (do_pop) rd_ptr_q <= advance(rd_ptr_q);
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (!push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

// File: rtl/core/cs_back.sv
module cs_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  cs_pkg::cmd_t head,
	output logic         pop,
	cs_out_if.source     result
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       has_q;
	logic       eot_q;
	logic       sub_q;
	logic       load;
	logic       two;

	assign load = !valid_q || result.ready;
	assign two  = (head.nbytes == 2'd2);
	// retire the command on its final beat
	assign pop  = load && head_valid && (!two || sub_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) sub_q <= two && !sub_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			byte_q <= (two && sub_q) ? head.second_byte :
				(head.nbytes == 2'd0) ? 8'h00 : head.first_byte;
			has_q  <= (head.nbytes != 2'd0);
			eot_q  <= head.last && (!two || sub_q);
		end
	end

	assign result.valid       = valid_q;
	assign result.out_byte    = byte_q;
	assign result.has_byte    = has_q;
	assign result.end_of_text = eot_q;

	a_second_beat_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> head_valid && two)
		else $error("second beat pending without a two-byte command");

endmodule

// File: rtl/core/comment_stripper.sv
// Strips C-style block and line comments from a byte stream. One byte is taken
// per cycle while the queue has room; a byte that releases a held slash yields
// two beats, which leave in turn, and a queue of QUEUE_DEPTH commands between
// the scanner and the output register absorbs that. An accepted byte is stored
// in the queue, then in the output register. Quoted literals, escapes included,
// pass unchanged; a line comment keeps its newline. The final byte (is_last)
// marks its last beat with end_of_text, or sends a bare end beat (has_byte low)
// when it yields no byte; the scanner then starts afresh for the next text.
module comment_stripper #(
	parameter int QUEUE_DEPTH = cs_pkg::QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	cs_in_if.sink    text,
	cs_out_if.source result
);

	logic         push, full, head_valid, pop;
	cs_pkg::cmd_t cmd, head;

	cs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.full   (full),
		.push   (push),
		.cmd    (cmd)
	);

	cs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr         (cmd),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	cs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);

endmodule

// File: tb/comment_stripper_checker.sv
module comment_stripper_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	input  logic       text_ready,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	input  logic       result_valid,
	input  logic       result_ready,
	input  logic [7:0] out_byte,
	input  logic       has_byte,
	input  logic       end_of_text,
	output int         pending,
	output int         failures
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_text;
	} stripped_beat_t;

	stripped_beat_t stripped_q[$];
	logic [2:0]     scan_mode;
	logic           quote_single;

	function automatic void note_failure(string what, stripped_beat_t want,
		stripped_beat_t got);
		if (failures < 10)
			$display("%0t: %s: expected byte %h has %b end %b, got byte %h has %b end %b",
				$time, what, want.out_byte, want.has_byte, want.end_of_text,
				got.out_byte, got.has_byte, got.end_of_text);
		failures = failures + 1;
	endfunction

	// Advance the scanner by one byte and queue the beats it gives.
	function automatic void predict_stripped(logic [7:0] b, logic last);
		logic [7:0]     emitted[2];
		int             n;
		logic           as_text;
		stripped_beat_t beat;
		n = 0;
		as_text = 1'b0;
		case (scan_mode)
			cs_pkg::MODE_SLASH: begin
				if (b == cs_pkg::CH_STAR) begin
					scan_mode = cs_pkg::MODE_BLOCK;
				end else if (b == cs_pkg::CH_SLASH) begin
					scan_mode = cs_pkg::MODE_LINE;
				end else begin
					// release the held slash ahead of this byte
					emitted[n] = cs_pkg::CH_SLASH;
					n++;
					scan_mode = cs_pkg::MODE_TEXT;
					as_text = 1'b1;
				end
			end
			cs_pkg::MODE_LINE: begin
				if (b == cs_pkg::CH_NL) begin
					emitted[n] = cs_pkg::CH_NL;
					n++;
					scan_mode = cs_pkg::MODE_TEXT;
				end
			end
			cs_pkg::MODE_BLOCK: begin
				if (b == cs_pkg::CH_STAR)
					scan_mode = cs_pkg::MODE_BLOCK_STAR;
			end
			cs_pkg::MODE_BLOCK_STAR: begin
				if (b == cs_pkg::CH_SLASH)
					scan_mode = cs_pkg::MODE_TEXT;
				else if (b != cs_pkg::CH_STAR)
					scan_mode = cs_pkg::MODE_BLOCK;
			end
			cs_pkg::MODE_QUOTE: begin
				emitted[n] = b;
				n++;
				if (b == cs_pkg::CH_BSLASH)
					scan_mode = cs_pkg::MODE_QUOTE_ESC;
				else if (b == (quote_single ? cs_pkg::CH_SQUOTE : cs_pkg::CH_DQUOTE))
					scan_mode = cs_pkg::MODE_TEXT;
			end
			cs_pkg::MODE_QUOTE_ESC: begin
				emitted[n] = b;
				n++;
				scan_mode = cs_pkg::MODE_QUOTE;
			end
			default: begin
				if (b == cs_pkg::CH_SLASH) begin
					if (last) begin
						emitted[n] = b;
						n++;
					end else begin
						scan_mode = cs_pkg::MODE_SLASH;
					end
				end else begin
					as_text = 1'b1;
				end
			end
		endcase
		if (as_text) begin
			if (b == cs_pkg::CH_DQUOTE || b == cs_pkg::CH_SQUOTE) begin
				quote_single = (b == cs_pkg::CH_SQUOTE);
				scan_mode = cs_pkg::MODE_QUOTE;
			end
			emitted[n] = b;
			n++;
		end
		for (int k = 0; k < n; k++) begin
			beat.out_byte = emitted[k];
			beat.has_byte = 1'b1;
			beat.end_of_text = last && (k == n - 1);
			stripped_q.push_back(beat);
		end
		if (last) begin
			if (n == 0) begin
				beat.out_byte = 8'h00;
				beat.has_byte = 1'b0;
				beat.end_of_text = 1'b1;
				stripped_q.push_back(beat);
			end
			scan_mode = cs_pkg::MODE_TEXT;
			quote_single = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stripped_beat_t got;
		stripped_beat_t want;
		if (!arst_n) begin
			scan_mode = cs_pkg::MODE_TEXT;
			quote_single = 1'b0;
			stripped_q.delete();
			pending <= 0;
		end else begin
			if (text_valid && text_ready)
				predict_stripped(in_byte, is_last);
			if (result_valid && result_ready) begin
				got.out_byte = out_byte;
				got.has_byte = has_byte;
				got.end_of_text = end_of_text;
				if (stripped_q.size() == 0) begin
					note_failure("beat with nothing expected", '0, got);
				end else begin
					want = stripped_q.pop_front();
					if (got !== want)
						note_failure("beat mismatch", want, got);
				end
			end
			pending <= stripped_q.size();
		end
	end

endmodule

// File: tb/comment_stripper_tb.sv
module comment_stripper_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 145;

	logic clk;
	logic arst_n;

	cs_in_if  text_ch();
	cs_out_if result_ch();

	int stripped_pending;
	int strip_failures;

	int tx_idle_pct = 11;
	int rx_idle_pct = 52;
	int phase = 0;
	int sent_items = 0;

	logic [7:0] text_buf[$];

	comment_stripper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch.sink),
		.result (result_ch.source)
	);

	comment_stripper_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_ch.valid),
		.text_ready   (text_ch.ready),
		.in_byte      (text_ch.in_byte),
		.is_last      (text_ch.is_last),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.out_byte     (result_ch.out_byte),
		.has_byte     (result_ch.has_byte),
		.end_of_text  (result_ch.end_of_text),
		.pending      (stripped_pending),
		.failures     (strip_failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_beat(logic [7:0] b, logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid   <= 1'b1;
		text_ch.in_byte <= b;
		text_ch.is_last <= last;
		do @(posedge clk); while (!text_ch.ready);
		sent_items++;
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_beat(text_buf[i], i == text_buf.size() - 1);
	endtask

	function automatic logic [7:0] letter();
		return 8'h61 + 8'($urandom_range(25));
	endfunction

	// Append one lexical piece of C-like source: plain bytes, literals, comments.
	function automatic void add_token();
		logic [7:0] q;
		int         len;
		case ($urandom_range(9))
			0, 1, 2: begin
				len = $urandom_range(1, 3);
				repeat (len) text_buf.push_back(letter());
			end
			3, 4: begin
				q = $urandom_range(1) ? cs_pkg::CH_SQUOTE : cs_pkg::CH_DQUOTE;
				text_buf.push_back(q);
				len = $urandom_range(0, 4);
				repeat (len) begin
					case ($urandom_range(5))
						0: text_buf.push_back(letter());
						1: text_buf.push_back(cs_pkg::CH_SLASH);
						2: text_buf.push_back(cs_pkg::CH_STAR);
						3: text_buf.push_back(q == cs_pkg::CH_SQUOTE ?
							cs_pkg::CH_DQUOTE : cs_pkg::CH_SQUOTE);
						4: begin
							text_buf.push_back(cs_pkg::CH_BSLASH);
							text_buf.push_back($urandom_range(1) ? q : 8'($urandom_range(255)));
						end
						default: text_buf.push_back(cs_pkg::CH_NL);
					endcase
				end
				text_buf.push_back(q);
			end
			5: begin
				text_buf.push_back(cs_pkg::CH_SLASH);
				text_buf.push_back(cs_pkg::CH_STAR);
				len = $urandom_range(0, 5);
				repeat (len) begin
					case ($urandom_range(4))
						0: text_buf.push_back(letter());
						1: text_buf.push_back(cs_pkg::CH_STAR);
						2: text_buf.push_back(cs_pkg::CH_SLASH);
						3: text_buf.push_back(cs_pkg::CH_NL);
						default: text_buf.push_back(cs_pkg::CH_DQUOTE);
					endcase
				end
				if ($urandom_range(1))
					text_buf.push_back(cs_pkg::CH_STAR);
				text_buf.push_back(cs_pkg::CH_STAR);
				text_buf.push_back(cs_pkg::CH_SLASH);
			end
			6: begin
				text_buf.push_back(cs_pkg::CH_SLASH);
				text_buf.push_back(cs_pkg::CH_SLASH);
				len = $urandom_range(0, 4);
				repeat (len) begin
					case ($urandom_range(4))
						0: text_buf.push_back(letter());
						1: text_buf.push_back(cs_pkg::CH_STAR);
						2: text_buf.push_back(cs_pkg::CH_SLASH);
						3: text_buf.push_back(cs_pkg::CH_SQUOTE);
						default: text_buf.push_back(cs_pkg::CH_BSLASH);
					endcase
				end
				text_buf.push_back(cs_pkg::CH_NL);
			end
			7: begin
				// slash that opens no comment
				text_buf.push_back(cs_pkg::CH_SLASH);
				text_buf.push_back($urandom_range(1) ? letter() : cs_pkg::CH_DQUOTE);
			end
			default: begin
				len = $urandom_range(1, 2);
				repeat (len) text_buf.push_back(8'($urandom_range(255)));
			end
		endcase
	endfunction

	initial begin
		int ntok;
		int keep;
		int phase_start;
		text_ch.valid   <= 1'b0;
		text_ch.in_byte <= 8'h00;
		text_ch.is_last <= 1'b0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// literal hiding comment marks, line comment, trailing slash on the last byte
		text_buf = '{8'h00, cs_pkg::CH_SLASH, "x", cs_pkg::CH_SQUOTE, cs_pkg::CH_BSLASH,
			cs_pkg::CH_SQUOTE, cs_pkg::CH_SLASH, cs_pkg::CH_SQUOTE, cs_pkg::CH_SLASH,
			cs_pkg::CH_SLASH, "q", cs_pkg::CH_NL, cs_pkg::CH_SLASH};
		send_text();
		// block comment with a run of stars, then a text ending in an open block
		text_buf = '{cs_pkg::CH_DQUOTE, cs_pkg::CH_SLASH, cs_pkg::CH_STAR, cs_pkg::CH_DQUOTE,
			cs_pkg::CH_SLASH, cs_pkg::CH_STAR, cs_pkg::CH_STAR, cs_pkg::CH_STAR,
			cs_pkg::CH_SLASH, cs_pkg::CH_SLASH, cs_pkg::CH_STAR};
		send_text();
		// released slash on the final byte gives two beats
		text_buf = '{cs_pkg::CH_SLASH, 8'hFF};
		send_text();

		for (int p = 0; p < 3; p++) begin
			phase = p;
			tx_idle_pct = (p == 0) ? 11 : (p == 1) ? 52 : 0;
			rx_idle_pct = (p == 0) ? 52 : (p == 1) ? 11 : 0;
			phase_start = sent_items;
			while (sent_items - phase_start < ITEMS_PER_PHASE) begin
				text_buf.delete();
				ntok = $urandom_range(1, 6);
				repeat (ntok) add_token();
				// cut some texts short so literals and comments stay open at the end
				if ($urandom_range(3) == 0) begin
					keep = $urandom_range(1, text_buf.size());
					while (text_buf.size() > keep)
						void'(text_buf.pop_back());
				end
				send_text();
			end
		end
		text_ch.valid <= 1'b0;

		wait (stripped_pending == 0);
		repeat (10) @(posedge clk);
		if (strip_failures == 0 && stripped_pending == 0)
			$display("** comment_stripper: PASSED **");
		else
			$display("** comment_stripper: FAILED **");
		$finish;
	end

	// Hold off the output once in the last phase so the queue fills and the input stalls.
	initial begin
		int  hold_left;
		int  phase2_cycles;
		bit  hold_done;
		hold_left = 0;
		phase2_cycles = 0;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase == 2 && !hold_done) begin
				phase2_cycles++;
				if (phase2_cycles == 8) begin
					hold_left = 60;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("** comment_stripper: FAILED **");
				$finish;
			end
		end
	end

endmodule
